// File: rtl/grid_bilinear_upsample_2x_unit_defines.svh
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_UPSAMPLE_2X_UNIT_DEFINES_SVH
`define GRID_BILINEAR_UPSAMPLE_2X_UNIT_DEFINES_SVH

// check a consequent in the same cycle
`define GBU_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check a consequent in the next cycle
`define GBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gbu_pkg.sv
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: package
// Shared constants, tap codes, per-item tag type and weight helpers.
// ----------------------------------------------------------------------------
package gbu_pkg;

  localparam int COORD_W       = 9;
  localparam int CFG_W         = 9;
  localparam int GRID_SIZE_RST = 16;
  localparam int MIN_SIDE      = 2;
  localparam int ROUND_BIAS    = 8;
  localparam int ROUND_SHIFT   = 4;

  typedef enum logic [1:0] {
    TAP_PREV_NEAR = 2'd0,
    TAP_CUR_NEAR  = 2'd1,
    TAP_END       = 2'd2
  } tap_t;

  typedef struct packed {
    logic [2:0] w_prev;
    logic [2:0] w_cur;
  } tap_w_t;

  typedef struct packed {
    logic [COORD_W-1:0] row_base;
    logic [COORD_W-1:0] col_base;
    logic               row_first;
    logic               row_last;
    logic               col_first;
    logic               col_last;
    logic               frame_end;
  } pos_tag_t;

  function automatic tap_w_t tap_weights(input logic first, input tap_t k);
    tap_w_t w;
    w.w_prev = 3'd0;
    w.w_cur  = 3'd4;
    if (!first) begin
      unique case (k)
        TAP_PREV_NEAR: begin
          w.w_prev = 3'd3;
          w.w_cur  = 3'd1;
        end
        TAP_CUR_NEAR: begin
          w.w_prev = 3'd1;
          w.w_cur  = 3'd3;
        end
        default: begin
          w.w_prev = 3'd0;
          w.w_cur  = 3'd4;
        end
      endcase
    end
    return w;
  endfunction

  function automatic tap_t next_tap(input tap_t k);
    tap_t n;
    unique case (k)
      TAP_PREV_NEAR: n = TAP_CUR_NEAR;
      TAP_CUR_NEAR:  n = TAP_END;
      default:       n = TAP_PREV_NEAR;
    endcase
    return n;
  endfunction

  function automatic logic tap_is_last(input logic first, input logic last, input tap_t k);
    return first || (last ? (k == TAP_END) : (k == TAP_CUR_NEAR));
  endfunction

endpackage

// File: rtl/gbu_fifo.sv
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: work queue
// Small register queue between the front classifier and the back end.
// ----------------------------------------------------------------------------
module gbu_fifo #(
  parameter int W     = 64,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    store_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CNTW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

endmodule

// File: rtl/gbu_front.sv
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: front end
// Accepts samples, tracks grid position, holds the line buffer and
// builds one queue entry per sample with its neighborhood.
// ----------------------------------------------------------------------------
module gbu_front import gbu_pkg::*; #(
  parameter int MAX_SIDE    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_grid_size,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          push_valid,
  input  logic                          push_ready,
  output pos_tag_t                      push_tag,
  output logic [4*SAMPLE_BITS-1:0]      push_data
);

  localparam int CW       = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int RST_SIDE = (GRID_SIZE_RST > MAX_SIDE) ? MAX_SIDE : GRID_SIZE_RST;
  localparam logic [CW-1:0] RST_LAST = CW'(RST_SIDE - 1);

  logic signed [SAMPLE_BITS-1:0] line_mem [MAX_SIDE];

  logic [CW-1:0]                 side_last_r, side_last_nxt;
  logic [CW-1:0]                 row_r, col_r;
  logic                          stage_valid_r;
  logic signed [SAMPLE_BITS-1:0] left_r, ul_r, up_q_r;
  logic signed [SAMPLE_BITS-1:0] x_r, left_s_r;
  pos_tag_t                      tag_r, tag_nxt;
  logic [31:0]                   gs_ext;
  logic [CW:0]                   row_dbl, col_dbl;
  logic                          accept, push_fire;

  assign cfg_ready  = 1'b1;
  assign push_valid = stage_valid_r;
  assign push_fire  = stage_valid_r && push_ready;
  assign in_ready   = !stage_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_tag   = tag_r;
  assign push_data  = {x_r, left_s_r, ul_r, up_q_r};

  assign gs_ext  = 32'(cfg_grid_size);
  assign row_dbl = {row_r, 1'b0} - (CW + 1)'(1);
  assign col_dbl = {col_r, 1'b0} - (CW + 1)'(1);

  always_comb begin
    if (gs_ext < 32'(MIN_SIDE)) begin
      side_last_nxt = CW'(MIN_SIDE - 1);
    end else if (gs_ext > 32'(MAX_SIDE)) begin
      side_last_nxt = CW'(MAX_SIDE - 1);
    end else begin
      side_last_nxt = CW'(gs_ext - 32'd1);
    end
  end

  always_comb begin
    tag_nxt.row_first = (row_r == '0);
    tag_nxt.col_first = (col_r == '0);
    tag_nxt.row_last  = (row_r == side_last_r);
    tag_nxt.col_last  = (col_r == side_last_r);
    tag_nxt.frame_end = tag_nxt.row_last && tag_nxt.col_last;
    tag_nxt.row_base  = tag_nxt.row_first ? '0 : COORD_W'(row_dbl);
    tag_nxt.col_base  = tag_nxt.col_first ? '0 : COORD_W'(col_dbl);
  end

  // read old entry, write new sample at the same column; drop the read in row 0
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_r] <= in_sample;
      up_q_r          <= tag_nxt.row_first ? '0 : line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= in_sample;
      left_s_r <= left_r;
      tag_r    <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_last_r   <= RST_LAST;
      row_r         <= '0;
      col_r         <= '0;
      left_r        <= '0;
      ul_r          <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        side_last_r <= side_last_nxt;
        row_r       <= '0;
        col_r       <= '0;
        left_r      <= '0;
        ul_r        <= '0;
      end else begin
        if (accept) begin
          left_r <= in_sample;
          if (tag_nxt.col_last) begin
            col_r <= '0;
            row_r <= tag_nxt.row_last ? '0 : row_r + CW'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
        if (push_fire) begin
          ul_r <= up_q_r;
        end
      end
      if (accept) begin
        stage_valid_r <= 1'b1;
      end else if (push_fire) begin
        stage_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/gbu_back.sv
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: back end
// Walks the row and column taps of one entry and emits one weighted,
// rounded result per cycle, unless the output stalls, through an output register.
// ----------------------------------------------------------------------------
module gbu_back import gbu_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop,
  input  pos_tag_t                      pop_tag,
  input  logic [4*SAMPLE_BITS-1:0]      pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_W-1:0]            out_row,
  output logic [COORD_W-1:0]            out_col,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          out_last_of_run,
  output logic                          out_frame_done
);

  localparam int SB   = SAMPLE_BITS;
  localparam int SUMW = SAMPLE_BITS + 6;

  logic                  busy_r, out_valid_r;
  pos_tag_t              cur_tag_r;
  logic [4*SB-1:0]       cur_data_r;
  tap_t                  a_r, b_r;
  tap_w_t                rw, cw;
  logic [4:0]            w_ul, w_up, w_left, w_x;
  logic signed [SB-1:0]  s_x, s_left, s_ul, s_up;
  logic signed [SUMW-1:0] sum, rnd;
  logic                  last_a, last_b, last_run, emit;

  assign s_x    = $signed(cur_data_r[4*SB-1:3*SB]);
  assign s_left = $signed(cur_data_r[3*SB-1:2*SB]);
  assign s_ul   = $signed(cur_data_r[2*SB-1:SB]);
  assign s_up   = $signed(cur_data_r[SB-1:0]);

  assign rw     = tap_weights(cur_tag_r.row_first, a_r);
  assign cw     = tap_weights(cur_tag_r.col_first, b_r);
  assign w_ul   = 5'(rw.w_prev) * 5'(cw.w_prev);
  assign w_up   = 5'(rw.w_prev) * 5'(cw.w_cur);
  assign w_left = 5'(rw.w_cur) * 5'(cw.w_prev);
  assign w_x    = 5'(rw.w_cur) * 5'(cw.w_cur);

  assign sum = SUMW'(s_ul)   * SUMW'($signed({1'b0, w_ul}))
             + SUMW'(s_up)   * SUMW'($signed({1'b0, w_up}))
             + SUMW'(s_left) * SUMW'($signed({1'b0, w_left}))
             + SUMW'(s_x)    * SUMW'($signed({1'b0, w_x}));
  assign rnd = (sum + SUMW'(ROUND_BIAS)) >>> ROUND_SHIFT;

  assign last_a   = tap_is_last(cur_tag_r.row_first, cur_tag_r.row_last, a_r);
  assign last_b   = tap_is_last(cur_tag_r.col_first, cur_tag_r.col_last, b_r);
  assign last_run = last_a && last_b;
  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign pop      = pop_valid && (!busy_r || (emit && last_run));
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_tag_r  <= pop_tag;
      cur_data_r <= pop_data;
    end
    if (emit) begin
      out_row         <= cur_tag_r.row_base + COORD_W'(a_r);
      out_col         <= cur_tag_r.col_base + COORD_W'(b_r);
      out_value       <= rnd[SB-1:0];
      out_last_of_run <= last_run;
      out_frame_done  <= last_run && cur_tag_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      a_r         <= TAP_PREV_NEAR;
      b_r         <= TAP_PREV_NEAR;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        busy_r <= 1'b1;
        a_r    <= TAP_PREV_NEAR;
        b_r    <= TAP_PREV_NEAR;
      end else if (emit) begin
        if (last_run) begin
          busy_r <= 1'b0;
          a_r    <= TAP_PREV_NEAR;
          b_r    <= TAP_PREV_NEAR;
        end else if (last_b) begin
          b_r <= TAP_PREV_NEAR;
          a_r <= next_tap(a_r);
        end else begin
          b_r <= next_tap(b_r);
        end
      end
    end
  end

endmodule

// File: rtl/grid_bilinear_upsample_2x_unit.sv
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: top level
// Streams an N x N grid of signed samples in raster order and emits the
// 2N x 2N bilinear upsampled grid, each result tagged with its position.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write grid_size (side N, clamped to 2..MAX_SIDE) while idle;
//            a write restarts the frame at row 0, column 0.
//   in_*   : one sample per transaction, raster order, valid/ready.
//   out_*  : one result per transaction, valid/ready. Each sample releases
//            1 to 9 results (4 in the interior), emitted row by row; the
//            last one carries out_last_of_run, the last of the grid also
//            out_frame_done.
// Path: front stage register, work queue, back end register, output register.
// Throughput: the back end emits one result per cycle while the output is
//   not stalled, and a sample releases about 4 results on average. Samples
//   are taken in consecutive cycles until the work queue fills.
// Reset: grid_size returns to 16, position and neighbors clear; the line
//   buffer is not cleared, row 0 never reads it.
// Stall: when out_ready is low the output register holds, the back end and
//   the work queue fill, then in_ready drops.
// ----------------------------------------------------------------------------
`include "grid_bilinear_upsample_2x_unit_defines.svh"

module grid_bilinear_upsample_2x_unit import gbu_pkg::*; #(
  parameter int MAX_SIDE    = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_grid_size,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_W-1:0]            out_row,
  output logic [COORD_W-1:0]            out_col,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          out_last_of_run,
  output logic                          out_frame_done
);

  localparam int DW = 4 * SAMPLE_BITS;
  localparam int QW = $bits(pos_tag_t) + DW;

  logic            fq_push_valid, fq_push_ready, fq_pop_valid, bk_pop;
  pos_tag_t        fr_tag, bk_tag;
  logic [DW-1:0]   fr_data, bk_data;
  logic [QW-1:0]   fq_out;

  gbu_front #(
    .MAX_SIDE    (MAX_SIDE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_grid_size (cfg_grid_size),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .push_valid    (fq_push_valid),
    .push_ready    (fq_push_ready),
    .push_tag      (fr_tag),
    .push_data     (fr_data)
  );

  gbu_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_push_valid),
    .push_ready (fq_push_ready),
    .push_data  ({fr_tag, fr_data}),
    .pop_valid  (fq_pop_valid),
    .pop        (bk_pop),
    .pop_data   (fq_out)
  );

  assign bk_tag  = fq_out[QW-1:DW];
  assign bk_data = fq_out[DW-1:0];

  gbu_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (fq_pop_valid),
    .pop             (bk_pop),
    .pop_tag         (bk_tag),
    .pop_data        (bk_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

  `GBU_ASSERT_IMPLIES(a_frame_done_ends_run, out_valid && out_frame_done, out_last_of_run, "frame_done without last_of_run")
  `GBU_ASSERT_IMPLIES(a_pop_nonempty, bk_pop, fq_pop_valid, "back end popped an empty queue")
  `GBU_ASSERT_NEXT(a_queue_keeps_entry, fq_pop_valid && !bk_pop, fq_pop_valid, "queue entry lost")

endmodule

// File: tb/gbu_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: scoreboard
// Predicts the tagged results of every accepted sample from its own copy of
// the line buffer, the neighbor samples and the grid position, and compares
// each received result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
package gbu_tb_pkg;
  import gbu_pkg::*;

  localparam int MAX_SIDE = 256;
  localparam int SAMPLE_W = 16;

  typedef struct {
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_of_run;
    logic                       frame_done;
  } pixel_t;

  class upsample_checker;
    pixel_t                     pending_pixels[$];
    int unsigned                side_len;
    logic signed [SAMPLE_W-1:0] line_buf[MAX_SIDE];
    logic signed [SAMPLE_W-1:0] left_px;
    logic signed [SAMPLE_W-1:0] upper_left_px;
    int unsigned                row_pos;
    int unsigned                col_pos;
    int                         errors;

    function new();
      foreach (line_buf[i]) line_buf[i] = '0;
      errors = 0;
      set_grid_size(CFG_W'(GRID_SIZE_RST));
    endfunction

    function void set_grid_size(input logic [CFG_W-1:0] size);
      side_len = size;
      if (side_len < MIN_SIDE) side_len = MIN_SIDE;
      if (side_len > MAX_SIDE) side_len = MAX_SIDE;
      left_px       = '0;
      upper_left_px = '0;
      row_pos       = 0;
      col_pos       = 0;
    endfunction

    function void axis_taps(input int unsigned p, output int cnt, output int unsigned pos[3],
                            output int w_prev[3], output int w_cur[3]);
      if (p == 0) begin
        pos[0] = 0; w_prev[0] = 0; w_cur[0] = 4;
        cnt = 1;
        return;
      end
      pos[0] = 2 * p - 1; w_prev[0] = 3; w_cur[0] = 1;
      pos[1] = 2 * p;     w_prev[1] = 1; w_cur[1] = 3;
      cnt = 2;
      if (p == side_len - 1) begin
        pos[2] = 2 * p + 1; w_prev[2] = 0; w_cur[2] = 4;
        cnt = 3;
      end
    endfunction

    function void take_sample(input logic signed [SAMPLE_W-1:0] x);
      int unsigned                rp[3];
      int unsigned                cp[3];
      int                         wu[3];
      int                         wr[3];
      int                         wl[3];
      int                         wc[3];
      int                         nr;
      int                         nc;
      int                         sum;
      bit                         frame_end;
      logic signed [SAMPLE_W-1:0] up;
      pixel_t                     px;
      up        = line_buf[col_pos];
      frame_end = (row_pos == side_len - 1) && (col_pos == side_len - 1);
      axis_taps(row_pos, nr, rp, wu, wr);
      axis_taps(col_pos, nc, cp, wl, wc);
      for (int a = 0; a < nr; a++) begin
        for (int b = 0; b < nc; b++) begin
          sum = wu[a] * wl[b] * upper_left_px + wu[a] * wc[b] * up
              + wr[a] * wl[b] * left_px + wr[a] * wc[b] * x;
          px.row         = COORD_W'(rp[a]);
          px.col         = COORD_W'(cp[b]);
          px.value       = SAMPLE_W'((sum + ROUND_BIAS) >>> ROUND_SHIFT);
          px.last_of_run = (a == nr - 1) && (b == nc - 1);
          px.frame_done  = px.last_of_run && frame_end;
          pending_pixels.push_back(px);
        end
      end
      upper_left_px     = up;
      line_buf[col_pos] = x;
      left_px           = x;
      col_pos++;
      if (col_pos >= side_len) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= side_len) row_pos = 0;
      end
    endfunction

    function void report(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                               input logic signed [SAMPLE_W-1:0] value,
                               input logic last_of_run, input logic frame_done);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                 $time, row, col, value);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (row !== want.row) report("out_row", want.row, row);
      if (col !== want.col) report("out_col", want.col, col);
      if (value !== want.value) report("out_value", want.value, value);
      if (last_of_run !== want.last_of_run)
        report("out_last_of_run", want.last_of_run, last_of_run);
      if (frame_done !== want.frame_done) report("out_frame_done", want.frame_done, frame_done);
    endfunction
  endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid bilinear 2x upsampler: testbench top
// Streams directed and random sample grids over several grid sizes, with
// random idle bursts on both channels, one long output stall and drained
// pauses, and checks every tagged result against the scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import gbu_pkg::*;
  import gbu_tb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_grid_size;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [COORD_W-1:0]         out_row;
  logic [COORD_W-1:0]         out_col;
  logic signed [SAMPLE_W-1:0] out_value;
  logic                       out_last_of_run;
  logic                       out_frame_done;

  upsample_checker board;
  bit              quiet;
  bit              hold_req;
  int              gap_left;
  int              items_sent;
  int              cycle_count = 0;

  grid_bilinear_upsample_2x_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_grid_size  (cfg_grid_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_last_of_run(out_last_of_run),
    .out_frame_done (out_frame_done)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_sample(s);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_grid_size(input logic [CFG_W-1:0] size);
    cfg_valid     <= 1'b1;
    cfg_grid_size <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_grid_size(size);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_items(input int count);
    logic signed [SAMPLE_W-1:0] s;
    for (int i = 0; i < count; i++) begin
      if (!quiet && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 10));
      case ($urandom_range(0, 7))
        0:       s = 16'sh7FFF;
        1:       s = 16'sh8000;
        default: s = SAMPLE_W'($urandom);
      endcase
      send_sample(s);
    end
  endtask

  initial begin
    board         = new();
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_grid_size = CFG_W'(GRID_SIZE_RST);
    in_valid      = 1'b0;
    in_sample     = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset size, stopped mid-row
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    drain();

    // smallest grid, restart mid-frame
    write_grid_size(9'd2);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    drain();

    // sizes below the minimum
    write_grid_size(9'd0);
    repeat (4) send_sample(16'sh8000);
    drain();
    write_grid_size(9'd1);
    repeat (4) send_sample(16'sh7FFF);
    drain();

    // sizes at and above the maximum
    write_grid_size(9'd511);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh8000);
    drain();
    write_grid_size(9'd256);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain();

    // fill the block under a long output stall
    write_grid_size(CFG_W'($urandom_range(40, 80)));
    hold_req = 1'b1;
    run_items(100);
    drain();

    while (items_sent < 320) begin
      if ($urandom_range(0, 7) == 0) begin
        write_grid_size(CFG_W'($urandom_range(200, 511)));
        run_items($urandom_range(8, 30));
      end else begin
        write_grid_size(CFG_W'($urandom_range(0, 8)));
        run_items(board.side_len * board.side_len * $urandom_range(1, 2)
                  + $urandom_range(0, board.side_len));
      end
      drain();
    end

    quiet = 1'b1;
    write_grid_size(9'd4);
    run_items(35);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending_pixels.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    gap_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        if (gap_left == 0 && !quiet && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 10);
        if (gap_left != 0) begin
          out_ready <= 1'b0;
          gap_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_row, out_col, out_value, out_last_of_run, out_frame_done);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/gbu_pkg.sv
rtl/gbu_fifo.sv
rtl/gbu_front.sv
rtl/gbu_back.sv
rtl/grid_bilinear_upsample_2x_unit.sv
tb/gbu_tb_pkg.sv
tb/tb.sv
